@@ rtl/irdir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdir_pkg
// Shared types, constants and tables for the IR ring direction core.
// ----------------------------------------------------------------------------
package irdir_pkg;

  localparam int SENSOR_COUNT    = 12;
  localparam int READS_PER_FRAME = 32;
  localparam int CORDIC_STEPS    = 16;
  localparam int CORDIC_RUN      = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam logic [27:0] DEG_Q16_360 = 28'd23592960;
  localparam logic [27:0] DEG_Q16_180 = 28'd11796480;

  typedef enum logic [1:0] {
    CFG_IGNORE_LEVEL   = 2'd0,
    CFG_DIRECTION_GAIN = 2'd1,
    CFG_STRENGTH_GAIN  = 2'd2,
    CFG_ANGLE_OFFSET   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        ignore_level;
    logic [8:0]        direction_gain;
    logic [8:0]        strength_gain;
    logic signed [9:0] angle_offset;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         count;
    logic signed [23:0] wx;
    logic signed [23:0] wy;
  } lane_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_ACCUM, ST_FILT, ST_TGT, ST_CORD, ST_OFS, ST_WRAP,
    ST_STRF, ST_PCTI, ST_PCT, ST_OUT
  } merge_state_t;

  function automatic logic signed [15:0] unit_x(input logic [3:0] i);
    logic signed [15:0] v;
    unique case (i)
      4'd0:  v = 16'sd16384;
      4'd1:  v = 16'sd14189;
      4'd2:  v = 16'sd8192;
      4'd3:  v = 16'sd0;
      4'd4:  v = -16'sd8192;
      4'd5:  v = -16'sd14189;
      4'd6:  v = -16'sd16384;
      4'd7:  v = -16'sd14189;
      4'd8:  v = -16'sd8192;
      4'd9:  v = 16'sd0;
      4'd10: v = 16'sd8192;
      4'd11: v = 16'sd14189;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] unit_y(input logic [3:0] i);
    logic signed [15:0] v;
    unique case (i)
      4'd0:  v = 16'sd0;
      4'd1:  v = 16'sd8192;
      4'd2:  v = 16'sd14189;
      4'd3:  v = 16'sd16384;
      4'd4:  v = 16'sd14189;
      4'd5:  v = 16'sd8192;
      4'd6:  v = 16'sd0;
      4'd7:  v = -16'sd8192;
      4'd8:  v = -16'sd14189;
      4'd9:  v = -16'sd16384;
      4'd10: v = -16'sd14189;
      4'd11: v = -16'sd8192;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [21:0] arctan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117305;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/irdir_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdir_lane
// One receiver lane: saturating hit counter, frame snapshot and weighted
// unit-vector products of the snapshot above the noise floor.
// ----------------------------------------------------------------------------
module irdir_lane
  import irdir_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] lane_id,
  input  logic       hit,
  input  logic       word_accept,
  input  logic       frame_end,
  input  logic [7:0] ignore_level,
  output lane_out_t  lane_o
);

  logic [7:0]         count_r, count_nxt;
  logic [7:0]         snap_r;
  logic [7:0]         weight;
  logic signed [23:0] wx_r, wy_r;

  always_comb begin
    count_nxt = count_r;
    if (hit && (count_r != 8'd255)) begin
      count_nxt = count_r + 8'd1;
    end
    weight = (snap_r > ignore_level) ? (snap_r - ignore_level) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
    end else if (word_accept) begin
      count_r <= frame_end ? 8'd0 : count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word_accept && frame_end) begin
      snap_r <= count_nxt;
    end
    wx_r <= 24'(unit_x(lane_id) * $signed({1'b0, weight}));
    wy_r <= 24'(unit_y(lane_id) * $signed({1'b0, weight}));
  end

  assign lane_o.count = snap_r;
  assign lane_o.wx    = wx_r;
  assign lane_o.wy    = wy_r;

endmodule

@@ rtl/irdir_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdir_merge
// Frame merge: walks the lanes for total, max, second and vector sum, runs the
// low-pass filters, the iterative CORDIC and the percent search, and holds the
// result word.
// ----------------------------------------------------------------------------
module irdir_merge
  import irdir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  cfg_t        cfg,
  input  lane_out_t   lanes [SENSOR_COUNT],
  output logic        idle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_sector,
  output logic [8:0]  out_degrees,
  output logic [6:0]  out_percent
);

  localparam logic [25:0] PCT_BIAS = 26'(READS_PER_FRAME * 512);
  localparam logic [25:0] PCT_STEP = 26'(READS_PER_FRAME * 1024);

  merge_state_t state_r, state_nxt;

  logic [3:0]         idx_r, idx_nxt;
  logic [11:0]        total_r, total_nxt;
  logic [7:0]         max_r, max_nxt, sec_r, sec_nxt;
  logic [3:0]         sector_r, sector_nxt;
  logic signed [26:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [23:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [17:0]        fs_r, fs_nxt, target_r, target_nxt;
  logic [13:0]        num_r, num_nxt;
  logic signed [42:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [27:0] cz_r, cz_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [8:0]         deg_r, deg_nxt;
  logic [25:0]        acc_r, acc_nxt, thr_r, thr_nxt;
  logic [6:0]         pct_r, pct_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [3:0]         osec_r, osec_nxt;
  logic [8:0]         odeg_r, odeg_nxt;
  logic [6:0]         opct_r, opct_nxt;

  lane_out_t          cur;
  logic signed [26:0] raw_x, raw_y;
  logic [11:0]        m12, s12, da, db;
  logic [29:0]        third;
  logic               nothing, tiny;
  logic signed [42:0] dx, dy, x0, y0;
  logic signed [27:0] rnd;

  function automatic logic signed [23:0] vec_filter(input logic signed [23:0] f,
                                                    input logic signed [26:0] raw,
                                                    input logic [8:0] gain);
    logic [8:0]         g;
    logic signed [26:0] diff;
    logic signed [36:0] prod;
    logic signed [36:0] sum;
    g    = (gain > 9'd256) ? 9'd256 : gain;
    diff = raw - 27'(f);
    prod = $signed({1'b0, g}) * diff;
    sum  = 37'(f) + ((prod + 37'sd128) >>> 8);
    if (sum > 37'sd8388607) begin
      return 24'sd8388607;
    end else if (sum < -37'sd8388608) begin
      return -24'sd8388608;
    end
    return sum[23:0];
  endfunction

  function automatic logic [17:0] str_filter(input logic [17:0] f,
                                             input logic [17:0] tgt,
                                             input logic [8:0] gain);
    logic [8:0]         g;
    logic signed [19:0] diff;
    logic signed [30:0] prod;
    logic signed [30:0] sum;
    g    = (gain > 9'd256) ? 9'd256 : gain;
    diff = $signed({2'b00, tgt}) - $signed({2'b00, f});
    prod = $signed({1'b0, g}) * diff;
    sum  = $signed({13'd0, f}) + ((prod + 31'sd128) >>> 8);
    if (sum < 31'sd0) begin
      return 18'd0;
    end else if (sum > 31'sd262143) begin
      return 18'd262143;
    end
    return sum[17:0];
  endfunction

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    max_nxt    = max_r;
    sec_nxt    = sec_r;
    sector_nxt = sector_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    fs_nxt     = fs_r;
    target_nxt = target_r;
    num_nxt    = num_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    step_nxt   = step_r;
    deg_nxt    = deg_r;
    acc_nxt    = acc_r;
    thr_nxt    = thr_r;
    pct_nxt    = pct_r;
    ovalid_nxt = ovalid_r && !out_ready;
    osec_nxt   = osec_r;
    odeg_nxt   = odeg_r;
    opct_nxt   = opct_r;

    cur     = lanes[idx_r];
    raw_x   = (sx_r + 27'sd8) >>> 4;
    raw_y   = (sy_r + 27'sd8) >>> 4;
    m12     = 12'({4'd0, max_r} * 12'd12);
    s12     = 12'({4'd0, sec_r} * 12'd12);
    da      = (m12 > total_r) ? (m12 - total_r) : 12'd0;
    db      = (s12 > total_r) ? (s12 - total_r) : 12'd0;
    third   = {15'd0, num_r + 14'd1} * 30'd21846;
    nothing = (max_r <= cfg.ignore_level);
    tiny    = (fx_r >= -24'sd1) && (fx_r <= 24'sd1) && (fy_r >= -24'sd1) && (fy_r <= 24'sd1);
    x0      = {{3{fx_r[23]}}, fx_r, 16'd0};
    y0      = {{3{fy_r[23]}}, fy_r, 16'd0};
    dx      = cy_r >>> step_r;
    dy      = cx_r >>> step_r;
    rnd     = cz_r + 28'sd32768;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_PREP;
          idx_nxt    = 4'd0;
          total_nxt  = 12'd0;
          max_nxt    = 8'd0;
          sec_nxt    = 8'd0;
          sector_nxt = 4'd0;
          sx_nxt     = 27'sd0;
          sy_nxt     = 27'sd0;
        end
      end
      ST_PREP: begin
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        total_nxt = total_r + 12'(cur.count);
        if (cur.count > max_r) begin
          sec_nxt    = max_r;
          max_nxt    = cur.count;
          sector_nxt = idx_r + 4'd1;
        end else if (cur.count > sec_r) begin
          sec_nxt = cur.count;
        end
        sx_nxt  = sx_r + 27'(cur.wx);
        sy_nxt  = sy_r + 27'(cur.wy);
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(SENSOR_COUNT - 1)) begin
          state_nxt = ST_FILT;
        end
      end
      ST_FILT: begin
        fx_nxt    = vec_filter(fx_r, raw_x, cfg.direction_gain);
        fy_nxt    = vec_filter(fy_r, raw_y, cfg.direction_gain);
        num_nxt   = 14'(da * 12'd3) + 14'(db);
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        target_nxt = nothing ? 18'd0 : (18'(num_r * 14'd21) + 18'(third[29:16]));
        deg_nxt    = 9'd0;
        step_nxt   = 5'd0;
        if (fx_r < 24'sd0) begin
          cx_nxt = -x0;
          cy_nxt = -y0;
          cz_nxt = $signed(DEG_Q16_180);
        end else begin
          cx_nxt = x0;
          cy_nxt = y0;
          cz_nxt = 28'sd0;
        end
        if (nothing) begin
          sector_nxt = 4'd0;
        end
        state_nxt = (nothing || tiny) ? ST_STRF : ST_CORD;
      end
      ST_CORD: begin
        if (cy_r > 43'sd0) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + $signed({6'd0, arctan_q16(step_r)});
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - $signed({6'd0, arctan_q16(step_r)});
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(CORDIC_RUN - 1)) begin
          state_nxt = ST_OFS;
        end
      end
      ST_OFS: begin
        cz_nxt    = cz_r + {{2{cfg.angle_offset[9]}}, cfg.angle_offset, 16'd0};
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (cz_r < 28'sd0) begin
          cz_nxt = cz_r + $signed(DEG_Q16_360);
        end else if (cz_r >= $signed(DEG_Q16_360)) begin
          cz_nxt = cz_r - $signed(DEG_Q16_360);
        end else begin
          deg_nxt   = rnd[24:16];
          state_nxt = ST_STRF;
        end
      end
      ST_STRF: begin
        fs_nxt    = str_filter(fs_r, target_r, cfg.strength_gain);
        state_nxt = ST_PCTI;
      end
      ST_PCTI: begin
        acc_nxt   = 26'(fs_r * 18'd100) + PCT_BIAS;
        thr_nxt   = PCT_STEP;
        pct_nxt   = 7'd0;
        state_nxt = ST_PCT;
      end
      ST_PCT: begin
        if ((pct_r < 7'd100) && (acc_r >= thr_r)) begin
          pct_nxt = pct_r + 7'd1;
          thr_nxt = thr_r + PCT_STEP;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          osec_nxt   = sector_r;
          odeg_nxt   = deg_r;
          opct_nxt   = pct_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      fx_r     <= 24'sd0;
      fy_r     <= 24'sd0;
      fs_r     <= 18'd0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      fx_r     <= fx_nxt;
      fy_r     <= fy_nxt;
      fs_r     <= fs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    total_r  <= total_nxt;
    max_r    <= max_nxt;
    sec_r    <= sec_nxt;
    sector_r <= sector_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    target_r <= target_nxt;
    num_r    <= num_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    step_r   <= step_nxt;
    deg_r    <= deg_nxt;
    acc_r    <= acc_nxt;
    thr_r    <= thr_nxt;
    pct_r    <= pct_nxt;
    osec_r   <= osec_nxt;
    odeg_r   <= odeg_nxt;
    opct_r   <= opct_nxt;
  end

  assign idle        = (state_r == ST_IDLE);
  assign out_valid   = ovalid_r;
  assign out_sector  = osec_r;
  assign out_degrees = odeg_r;
  assign out_percent = opct_r;

endmodule

@@ rtl/ir_ring_direction_strength_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_ring_direction_strength_core
// Twelve-receiver IR ring: per-sensor hit counting and per-frame direction
// and strength estimate.
// ----------------------------------------------------------------------------
// Each input word is one read of the twelve receivers. On the last read of a
// frame the counts are snapshotted into the lanes and the merge unit runs the
// lane walk, the vector and strength filters, the iterative CORDIC with its
// angle offset and wrap, and the percent search; in_tready is low during that
// time. The last read of a frame also waits until the output register is free.
// One result word leaves per frame and is held in an output register until
// taken.
module ir_ring_direction_strength_core
  import irdir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sensor_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] direction_sector, [12:4] direction_degrees,
                                  // [19:13] strength_pct
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  cfg_t       cfg_r;
  logic [7:0] read_idx_r;
  logic       last_read, word_accept, frame_end, merge_idle;
  lane_out_t  lanes [SENSOR_COUNT];
  logic [3:0] o_sector;
  logic [8:0] o_degrees;
  logic [6:0] o_percent;

  assign last_read   = (read_idx_r >= 8'(READS_PER_FRAME - 1));
  assign in_tready   = merge_idle && (!last_read || !out_tvalid || out_tready);
  assign word_accept = in_tvalid && in_tready;
  assign frame_end   = word_accept && last_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignore_level   <= 8'd0;
      cfg_r.direction_gain <= 9'd256;
      cfg_r.strength_gain  <= 9'd256;
      cfg_r.angle_offset   <= 10'sd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IGNORE_LEVEL:   cfg_r.ignore_level   <= cfg_data[7:0];
        CFG_DIRECTION_GAIN: cfg_r.direction_gain <= cfg_data[8:0];
        CFG_STRENGTH_GAIN:  cfg_r.strength_gain  <= cfg_data[8:0];
        CFG_ANGLE_OFFSET:   cfg_r.angle_offset   <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_idx_r <= 8'd0;
    end else if (word_accept) begin
      read_idx_r <= last_read ? 8'd0 : read_idx_r + 8'd1;
    end
  end

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    irdir_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .lane_id      (4'(i)),
      .hit          (!in_tdata[i]),
      .word_accept  (word_accept),
      .frame_end    (frame_end),
      .ignore_level (cfg_r.ignore_level),
      .lane_o       (lanes[i])
    );
  end

  irdir_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (frame_end),
    .cfg         (cfg_r),
    .lanes       (lanes),
    .idle        (merge_idle),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sector  (o_sector),
    .out_degrees (o_degrees),
    .out_percent (o_percent)
  );

  assign out_tdata = {4'd0, o_percent, o_degrees, o_sector};

endmodule

@@ tb/ir_ring_direction_strength_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_ring_direction_strength_checker
// Watches the read, result and register ports of the IR ring core, predicts
// each frame's sector, angle and strength, and compares every result word.
// ----------------------------------------------------------------------------
module ir_ring_direction_strength_checker
  import irdir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          pending,
  output int          failures,
  output int          frames_checked
);

  typedef struct packed {
    logic [3:0] sector;
    logic [8:0] degrees;
    logic [6:0] percent;
  } frame_result_t;

  localparam longint VEC_HI = 8388607;
  localparam longint VEC_LO = -8388608;
  localparam longint STR_HI = 262143;
  localparam longint FULL_TURN = 23592960;
  localparam longint COS_Q14[12] = '{16384, 14189, 8192, 0, -8192, -14189,
                                     -16384, -14189, -8192, 0, 8192, 14189};
  localparam longint SIN_Q14[12] = '{0, 8192, 14189, 16384, 14189, 8192,
                                     0, -8192, -14189, -16384, -14189, -8192};
  localparam longint ATAN_DEG_Q16[24] = '{2949120, 1740967, 919879, 466945,
    234379, 117305, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7, 4, 2, 1, 0};

  frame_result_t expected_frames[$];
  logic [7:0]  hits [SENSOR_COUNT];
  logic [7:0]  read_count;
  longint      filt_x, filt_y, filt_strength;
  logic [7:0]  ignore_level;
  logic [8:0]  dir_gain, str_gain;
  logic signed [9:0] offset_deg;

  function automatic longint smooth(longint f, longint target, logic [8:0] gain);
    longint g;
    g = (gain > 256) ? 256 : gain;
    return f + ((g * (target - f) + 128) >>> 8);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [8:0] heading(longint vx, longint vy);
    longint x, y, z, dx, dy;
    int steps;
    x = vx * 65536;
    y = vy * 65536;
    z = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 180 * 65536;
    end
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_DEG_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_DEG_Q16[i];
      end
    end
    z += longint'(offset_deg) * 65536;
    z = ((z % FULL_TURN) + FULL_TURN) % FULL_TURN;
    return 9'((z + 32768) >>> 16);
  endfunction

  function automatic void count_read(logic [11:0] bits);
    longint total, top, runner, raw_x, raw_y, num, target, denom, pct;
    logic [3:0] sector;
    logic [8:0] degrees;
    frame_result_t r;
    total = 0; top = 0; runner = 0; raw_x = 0; raw_y = 0; num = 0; target = 0;
    sector = 0; degrees = 0;
    for (int i = 0; i < SENSOR_COUNT; i++)
      if (!bits[i] && hits[i] != 8'd255) hits[i]++;
    read_count++;
    if (read_count < READS_PER_FRAME) return;
    read_count = 0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      total += hits[i];
      if (hits[i] > top) begin
        runner = top;
        top = hits[i];
        sector = 4'(i + 1);
      end else if (hits[i] > runner) begin
        runner = hits[i];
      end
      if (hits[i] > ignore_level) begin
        raw_x += COS_Q14[i] * (hits[i] - ignore_level);
        raw_y += SIN_Q14[i] * (hits[i] - ignore_level);
      end
    end
    raw_x = (raw_x + 8) >>> 4;
    raw_y = (raw_y + 8) >>> 4;
    filt_x = clip(smooth(filt_x, raw_x, dir_gain), VEC_LO, VEC_HI);
    filt_y = clip(smooth(filt_y, raw_y, dir_gain), VEC_LO, VEC_HI);
    if (top <= ignore_level) begin
      sector = 0;
    end else begin
      if (!(filt_x >= -1 && filt_x <= 1 && filt_y >= -1 && filt_y <= 1))
        degrees = heading(filt_x, filt_y);
      if (12 * top > total) num += 3 * (12 * top - total);
      if (12 * runner > total) num += 12 * runner - total;
      target = (num * 1024 + 24) / 48;
    end
    filt_strength = clip(smooth(filt_strength, target, str_gain), 0, STR_HI);
    denom = longint'(READS_PER_FRAME) * 1024;
    pct = clip((filt_strength * 100 + denom / 2) / denom, 0, 100);
    for (int i = 0; i < SENSOR_COUNT; i++) hits[i] = 0;
    r.sector = sector;
    r.degrees = degrees;
    r.percent = 7'(pct);
    expected_frames.push_back(r);
  endfunction

  always @(posedge clk) begin
    frame_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) hits[i] = 0;
      read_count = 0;
      filt_x = 0; filt_y = 0; filt_strength = 0;
      ignore_level = 0; dir_gain = 256; str_gain = 256; offset_deg = 0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IGNORE_LEVEL:   ignore_level = cfg_data[7:0];
          CFG_DIRECTION_GAIN: dir_gain = cfg_data[8:0];
          CFG_STRENGTH_GAIN:  str_gain = cfg_data[8:0];
          CFG_ANGLE_OFFSET:   offset_deg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.sector = out_tdata[3:0];
        got.degrees = out_tdata[12:4];
        got.percent = out_tdata[19:13];
        if (expected_frames.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result word: sector %0d degrees %0d percent %0d",
                     got.sector, got.degrees, got.percent);
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (got != want) begin
            failures++;
            if (failures <= 10)
              $display("frame %0d: expected sector %0d degrees %0d percent %0d, got %0d %0d %0d",
                       frames_checked, want.sector, want.degrees, want.percent,
                       got.sector, got.degrees, got.percent);
          end
        end
      end
      if (in_tvalid && in_tready) count_read(in_tdata[11:0]);
    end
    pending <= expected_frames.size();
  end

  initial begin
    pending = 0;
    failures = 0;
    frames_checked = 0;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames of receiver reads into the IR ring core under changing
// register settings, back pressure and idle gaps, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import irdir_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  int          pending, failures, frames_checked;
  int          send_idle_pct = 15;
  int          take_idle_pct = 53;
  int          reads_sent = 0;
  bit          long_hold_done = 1'b0;

  always #2 clk = ~clk;

  ir_ring_direction_strength_core dut (.*);

  ir_ring_direction_strength_checker checker_i (.*);

  always @(posedge clk) begin
    if (!long_hold_done && reads_sent >= 1000) begin
      out_tready <= 1'b0;
      repeat (600) @(posedge clk);
      long_hold_done = 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic send_read(logic [11:0] bits);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, bits};
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    reads_sent <= reads_sent + 1;
  endtask

  // Frame kinds: 0 a beam from one side, 1 uniform noise, 2 silence, 3 all lit.
  task automatic send_frame(int kind, int aim);
    int odds [SENSOR_COUNT];
    int spread, ring_gap;
    logic [11:0] bits;
    spread = $urandom_range(1, 4);
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      ring_gap = (i - aim + SENSOR_COUNT) % SENSOR_COUNT;
      if (ring_gap > 6) ring_gap = SENSOR_COUNT - ring_gap;
      case (kind)
        0: odds[i] = (ring_gap > spread) ? $urandom_range(10) : 100 - 20 * ring_gap;
        1: odds[i] = 50;
        2: odds[i] = 0;
        default: odds[i] = 100;
      endcase
    end
    for (int r = 0; r < READS_PER_FRAME; r++) begin
      for (int i = 0; i < SENSOR_COUNT; i++)
        bits[i] = !($urandom_range(99) < odds[i]);
      send_read(bits);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int floors [9] = '{0, 255, 3, 10, 0, 5, 0, 1, 0};
    int dgains [9] = '{256, 0, 511, 64, 200, 256, 0, 128, 256};
    int sgains [9] = '{256, 511, 0, 32, 256, 100, 0, 300, 256};
    int offsets [9] = '{0, -359, 359, -512, 511, 90, 0, -1, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(3, 0);
    send_frame(2, 0);
    for (int r = 0; r < READS_PER_FRAME; r++) send_read(12'hFFE);
    for (int r = 0; r < READS_PER_FRAME; r++) send_read(12'h7FF);
    for (int r = 0; r < READS_PER_FRAME; r++) send_read(12'hFF5);
    send_frame(3, 0);

    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      if (ph == 6) begin
        floors[ph] = $urandom_range(12);
        dgains[ph] = $urandom_range(511);
        sgains[ph] = $urandom_range(511);
        offsets[ph] = $urandom_range(1023);
      end
      write_reg(CFG_IGNORE_LEVEL, {2'($urandom), 8'(floors[ph])});
      write_reg(CFG_DIRECTION_GAIN, {1'($urandom), 9'(dgains[ph])});
      write_reg(CFG_STRENGTH_GAIN, {1'($urandom), 9'(sgains[ph])});
      write_reg(CFG_ANGLE_OFFSET, 10'(offsets[ph]));
      send_idle_pct = (ph < 3) ? 15 : ((ph < 6) ? 53 : 0);
      take_idle_pct = (ph < 3) ? 53 : ((ph < 6) ? 15 : 0);
      for (int f = 0; f < 6; f++) begin
        case ($urandom_range(9))
          0: send_frame(1, 0);
          1: send_frame(2, 0);
          2: send_frame(3, 0);
          default: send_frame(0, $urandom_range(SENSOR_COUNT - 1));
        endcase
      end
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d receiver reads over nine register settings; %0d frame results checked.",
             reads_sent, frames_checked);
    $display("Settings covered noise floor and gain extremes, offset wrap both ways and a long output stall.");
    if (failures == 0) begin
      $display("ir_ring_direction_strength_core test passed");
    end else begin
      $display("ir_ring_direction_strength_core test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ir_ring_direction_strength_core test failed");
    $finish;
  end

endmodule
